// ===== hdl/icy_metadata_stream_splitter_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the metadata stream splitter
// Both assume a clock named clk and an active-low reset named arst_n.
// ---------------------------------------------------------------------------
`ifndef ICY_METADATA_STREAM_SPLITTER_MACROS_SVH
`define ICY_METADATA_STREAM_SPLITTER_MACROS_SVH

// same-cycle implication
`define IMSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IMSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/imss_pkg.sv =====
// ---------------------------------------------------------------------------
// imss_pkg
// Types, constants and helpers shared by the metadata stream splitter.
// ---------------------------------------------------------------------------
package imss_pkg;

	localparam int unsigned INTERVAL_W     = 20;
	localparam int unsigned COUNT_W        = 12;
	localparam logic [19:0] INTERVAL_RESET = 20'd8192;

	localparam logic [3:0] PREFIX_LEN = 4'd13;
	localparam logic [7:0] CHAR_S     = 8'h53;
	localparam logic [7:0] CHAR_QUOTE = 8'h27;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_AUDIO  = 2'd0,
		KIND_CAND   = 2'd1,
		KIND_FINISH = 2'd2
	} kind_t;

	typedef enum logic {
		PH_AUDIO = 1'b0,
		PH_META  = 1'b1
	} phase_t;

	// one queue entry: one or two output beats
	typedef struct packed {
		kind_t               kind;
		logic [7:0]          data_byte;
		logic [COUNT_W-1:0]  title_index;
		logic                two;          // finish beat follows the first
		logic [COUNT_W-1:0]  title_length;
	} entry_t;

	function automatic logic [7:0] prefix_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = 8'h53; // S
			4'd1:    c = 8'h74; // t
			4'd2:    c = 8'h72; // r
			4'd3:    c = 8'h65; // e
			4'd4:    c = 8'h61; // a
			4'd5:    c = 8'h6D; // m
			4'd6:    c = 8'h54; // T
			4'd7:    c = 8'h69; // i
			4'd8:    c = 8'h74; // t
			4'd9:    c = 8'h6C; // l
			4'd10:   c = 8'h65; // e
			4'd11:   c = 8'h3D; // =
			4'd12:   c = 8'h27; // '
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/imss_front.sv =====
// ---------------------------------------------------------------------------
// imss_front
// Byte classifier: audio counting, length bytes, prefix match and title
// tracking. Emits at most one queue entry per accepted byte.
// ---------------------------------------------------------------------------
`include "icy_metadata_stream_splitter_macros.svh"

module imss_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_fire,
	input  logic [7:0]                          in_byte,
	input  logic                                cfg_we,
	input  logic [imss_pkg::INTERVAL_W-1:0]     cfg_wdata,
	output logic                                push,
	output imss_pkg::entry_t                    push_entry
);

	imss_pkg::phase_t phase_q, phase_d;

	logic [imss_pkg::INTERVAL_W-1:0] interval_q, interval_d;
	logic [imss_pkg::INTERVAL_W-1:0] audio_left_q, audio_left_d;
	logic [imss_pkg::COUNT_W-1:0]    meta_left_q, meta_left_d;
	logic [3:0]                      pos_q, pos_d;
	logic                            open_q, open_d;
	logic                            closed_q, closed_d;
	logic [imss_pkg::COUNT_W-1:0]    count_q, count_d;
	logic [imss_pkg::COUNT_W-1:0]    final_q, final_d;
	logic [imss_pkg::COUNT_W-1:0]    lastq_q, lastq_d;
	logic                            quote_q, quote_d;
	logic                            prevq_q, prevq_d;

	logic                            meta_end;
	logic [3:0]                      pos_nx;
	logic [imss_pkg::COUNT_W-1:0]    fin_len;

	assign meta_end = (meta_left_q <= imss_pkg::COUNT_W'(1));
	assign pos_nx   = (in_byte == imss_pkg::prefix_char(pos_q)) ? pos_q + 4'd1 :
		((in_byte == imss_pkg::CHAR_S) ? 4'd1 : 4'd0);

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			imss_pkg::PH_AUDIO: begin
				if (in_fire && audio_left_q == '0 && in_byte != 8'h00)
					phase_d = imss_pkg::PH_META;
			end
			imss_pkg::PH_META: begin
				if (in_fire && meta_end)
					phase_d = imss_pkg::PH_AUDIO;
			end
			default: phase_d = imss_pkg::PH_AUDIO;
		endcase
	end

	// datapath and entry
	always_comb begin
		interval_d   = interval_q;
		audio_left_d = audio_left_q;
		meta_left_d  = meta_left_q;
		pos_d        = pos_q;
		open_d       = open_q;
		closed_d     = closed_q;
		count_d      = count_q;
		final_d      = final_q;
		lastq_d      = lastq_q;
		quote_d      = quote_q;
		prevq_d      = prevq_q;
		fin_len      = '0;
		push         = 1'b0;
		push_entry   = '{kind: imss_pkg::KIND_AUDIO, data_byte: in_byte,
			title_index: '0, two: 1'b0, title_length: '0};

		if (in_fire) begin
			case (phase_q)
				imss_pkg::PH_AUDIO: begin
					if (audio_left_q != '0) begin
						audio_left_d = audio_left_q - imss_pkg::INTERVAL_W'(1);
						push         = 1'b1;
					end else begin
						pos_d    = '0;
						open_d   = 1'b0;
						closed_d = 1'b0;
						count_d  = '0;
						final_d  = '0;
						lastq_d  = '0;
						quote_d  = 1'b0;
						prevq_d  = 1'b0;
						if (in_byte == 8'h00)
							audio_left_d = interval_q;
						else
							meta_left_d = {in_byte, 4'h0};
					end
				end
				imss_pkg::PH_META: begin
					meta_left_d = meta_end ? '0 : meta_left_q - imss_pkg::COUNT_W'(1);
					if (open_q) begin
						if (!closed_q && prevq_q && in_byte == imss_pkg::CHAR_SEMI) begin
							final_d  = count_q - imss_pkg::COUNT_W'(1);
							closed_d = 1'b1;
						end
						if (in_byte == imss_pkg::CHAR_QUOTE) begin
							lastq_d = count_q;
							quote_d = 1'b1;
							prevq_d = 1'b1;
						end else begin
							prevq_d = 1'b0;
						end
						count_d                = count_q + imss_pkg::COUNT_W'(1);
						push                   = 1'b1;
						push_entry.kind        = imss_pkg::KIND_CAND;
						push_entry.title_index = count_q;
						push_entry.two         = meta_end;
					end else begin
						pos_d = pos_nx;
						if (pos_nx >= imss_pkg::PREFIX_LEN) begin
							open_d = 1'b1;
							pos_d  = '0;
						end
						if (meta_end) begin
							push                 = 1'b1;
							push_entry.kind      = imss_pkg::KIND_FINISH;
							push_entry.data_byte = 8'h00;
						end
					end
					if (meta_end) begin
						if (open_d)
							fin_len = closed_d ? final_d : (quote_d ? lastq_d : '0);
						push_entry.title_length = fin_len;
						audio_left_d = interval_q;
						pos_d    = '0;
						open_d   = 1'b0;
						closed_d = 1'b0;
						count_d  = '0;
						final_d  = '0;
						lastq_d  = '0;
						quote_d  = 1'b0;
						prevq_d  = 1'b0;
					end
				end
				default: ;
			endcase
		end

		if (cfg_we) begin
			interval_d = cfg_wdata;
			if (phase_q == imss_pkg::PH_AUDIO)
				audio_left_d = cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= imss_pkg::PH_AUDIO;
			interval_q   <= imss_pkg::INTERVAL_RESET;
			audio_left_q <= imss_pkg::INTERVAL_RESET;
			meta_left_q  <= '0;
			pos_q        <= '0;
			open_q       <= 1'b0;
			closed_q     <= 1'b0;
			count_q      <= '0;
			final_q      <= '0;
			lastq_q      <= '0;
			quote_q      <= 1'b0;
			prevq_q      <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			interval_q   <= interval_d;
			audio_left_q <= audio_left_d;
			meta_left_q  <= meta_left_d;
			pos_q        <= pos_d;
			open_q       <= open_d;
			closed_q     <= closed_d;
			count_q      <= count_d;
			final_q      <= final_d;
			lastq_q      <= lastq_d;
			quote_q      <= quote_d;
			prevq_q      <= prevq_d;
		end
	end

	`IMSS_ASSERT_NOW(a_meta_left_live, phase_q == imss_pkg::PH_META, meta_left_q != '0, "block with no bytes left")
	`IMSS_ASSERT_NOW(a_matcher_idle, open_q, pos_q == '0, "matcher active inside title")

endmodule

// ===== hdl/imss_fifo.sv =====
// ---------------------------------------------------------------------------
// imss_fifo
// Short entry queue between classifier and output stage.
// ---------------------------------------------------------------------------
`include "icy_metadata_stream_splitter_macros.svh"

module imss_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  imss_pkg::entry_t push_entry,
	input  logic             pop,
	output imss_pkg::entry_t head,
	output logic             empty,
	output logic             full
);

	imss_pkg::entry_t mem_q [imss_pkg::FIFO_DEPTH];

	logic [imss_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [imss_pkg::FIFO_CW-1:0] count_q;
	logic                         do_push, do_pop;

	localparam logic [imss_pkg::FIFO_AW-1:0] LAST_PTR = imss_pkg::FIFO_AW'(imss_pkg::FIFO_DEPTH - 1);
	localparam logic [imss_pkg::FIFO_CW-1:0] FULL_CNT = imss_pkg::FIFO_CW'(imss_pkg::FIFO_DEPTH);

	assign empty   = (count_q == '0);
	assign full    = (count_q == FULL_CNT);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + imss_pkg::FIFO_AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + imss_pkg::FIFO_AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + imss_pkg::FIFO_CW'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - imss_pkg::FIFO_CW'(1);
		end
	end

	`IMSS_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")

endmodule

// ===== hdl/imss_back.sv =====
// ---------------------------------------------------------------------------
// imss_back
// Output stage: expands queue entries into one or two beats and holds
// them in the output register.
// ---------------------------------------------------------------------------
`include "icy_metadata_stream_splitter_macros.svh"

module imss_back (
	input  logic             clk,
	input  logic             arst_n,
	input  imss_pkg::entry_t head,
	input  logic             empty,
	output logic             pop,
	output logic             m_valid,
	input  logic             m_ready,
	output logic [31:0]      m_data,
	output logic [1:0]       m_user,
	output logic             m_last
);

	logic             second_q;
	logic             load;
	logic             fin_beat;
	imss_pkg::kind_t  beat_kind;
	logic [31:0]      beat_data;
	logic             beat_last;

	assign load     = !empty && (!m_valid || m_ready);
	assign fin_beat = second_q || head.kind == imss_pkg::KIND_FINISH;
	assign pop      = load && (second_q || !head.two);

	always_comb begin
		if (fin_beat) begin
			beat_kind = imss_pkg::KIND_FINISH;
			beat_data = {head.title_length, 12'h000, 8'h00};
			beat_last = 1'b1;
		end else begin
			beat_kind = head.kind;
			beat_data = {12'h000, head.title_index, head.data_byte};
			beat_last = !head.two;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_data <= beat_data;
			m_user <= beat_kind;
			m_last <= beat_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load)
				m_valid <= 1'b1;
			else if (m_ready)
				m_valid <= 1'b0;
			if (load)
				second_q <= head.two && !second_q;
		end
	end

	`IMSS_ASSERT_NOW(a_second_has_entry, second_q, !empty && head.two, "finish beat without its entry")

endmodule

// ===== hdl/icy_metadata_stream_splitter.sv =====
// ---------------------------------------------------------------------------
// icy_metadata_stream_splitter
// Splits an interleaved audio/metadata byte stream into audio beats,
// candidate title beats and a title-finished beat per metadata block.
// ---------------------------------------------------------------------------
// channel    dir  payload
// s_axis     in   tdata[7:0] stream_byte
// m_axis     out  tdata data_byte/title_index/title_length, tuser kind, tlast
// cfg        in   meta_interval_we / meta_interval_wdata (meta_interval)
//
// One byte accepted per cycle while the queue has room. The last byte of a
// block that is a title byte yields two beats, both sent through the single
// output register. A four-entry queue decouples input from output stalls.
// Reset sets meta_interval to 8192 and starts in the audio phase; no clearing
// pass is needed.
// ---------------------------------------------------------------------------
module icy_metadata_stream_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [19:8] title_index, [31:20] title_length
	output logic [1:0]  m_axis_tuser,   // [1:0] kind
	output logic        m_axis_tlast,
	input  logic        meta_interval_we,
	input  logic [19:0] meta_interval_wdata
);

	logic             in_fire;
	logic             push;
	imss_pkg::entry_t push_entry;
	imss_pkg::entry_t head;
	logic             empty, full, pop;

	assign s_axis_tready = !full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	imss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.in_byte    (s_axis_tdata),
		.cfg_we     (meta_interval_we),
		.cfg_wdata  (meta_interval_wdata),
		.push       (push),
		.push_entry (push_entry)
	);

	imss_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	imss_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.empty   (empty),
		.pop     (pop),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_data  (m_axis_tdata),
		.m_user  (m_axis_tuser),
		.m_last  (m_axis_tlast)
	);

endmodule

// ===== tb/sv/icy_metadata_stream_splitter_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// icy_metadata_stream_splitter_tb
// Drives an interleaved audio/metadata byte stream into the splitter and
// checks every output beat against a cycle-free predictor of the deframer.
// A short directed table comes first, then randomised frames with mostly
// well-formed title blocks, random sender bursts and receiver stalls.
// ---------------------------------------------------------------------------
module icy_metadata_stream_splitter_tb;

	typedef struct packed {
		imss_pkg::kind_t kind;
		logic [7:0]      data;
		logic [11:0]     idx;
		logic [11:0]     len;
		logic            last;
	} beat_t;

	typedef struct packed {
		logic        cfg;
		logic [19:0] cfg_val;
		logic [7:0]  b;
		logic        typed;
	} row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_t;

	localparam logic [103:0] TITLE_TAG    = "StreamTitle='";
	localparam logic [19:0]  INTERVAL_MAX = 20'hFFFFF;
	localparam int           BIG_LEN      = 48;

	// typed rows are audio beats whose value is the byte itself
	localparam row_t STEPS [25] = '{
		'{1'b0, 20'd0, 8'h00, 1'b1},
		'{1'b0, 20'd0, 8'hFF, 1'b1},
		'{1'b0, 20'd0, 8'h5A, 1'b1},
		'{1'b0, 20'd0, 8'hA5, 1'b1},
		'{1'b1, 20'd0, 8'h00, 1'b0},  // zero interval, empty block
		'{1'b0, 20'd0, 8'h01, 1'b0},  // 16-byte block
		'{1'b0, 20'd0, "S",   1'b0},
		'{1'b0, 20'd0, "t",   1'b0},
		'{1'b0, 20'd0, "r",   1'b0},
		'{1'b0, 20'd0, "e",   1'b0},
		'{1'b0, 20'd0, "a",   1'b0},
		'{1'b0, 20'd0, "m",   1'b0},
		'{1'b0, 20'd0, "T",   1'b0},
		'{1'b0, 20'd0, "i",   1'b0},
		'{1'b0, 20'd0, "t",   1'b0},
		'{1'b0, 20'd0, "l",   1'b0},
		'{1'b0, 20'd0, "e",   1'b0},
		'{1'b0, 20'd0, "=",   1'b0},
		'{1'b0, 20'd0, "'",   1'b0},
		'{1'b0, 20'd0, "a",   1'b0},
		'{1'b0, 20'd0, "'",   1'b0},
		'{1'b0, 20'd0, ";",   1'b0},  // closes title, then finish beat
		'{1'b1, 20'd1, 8'h80, 1'b1},
		'{1'b0, 20'd0, 8'h00, 1'b0},
		'{1'b0, 20'd0, 8'hFF, 1'b1}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        meta_interval_we = 1'b0;
	logic [19:0] meta_interval_wdata = 20'd0;

	// predictor state
	logic [19:0]      ivl = imss_pkg::INTERVAL_RESET;
	imss_pkg::phase_t ph = imss_pkg::PH_AUDIO;
	logic [19:0]      audio_cnt = imss_pkg::INTERVAL_RESET;
	logic [11:0]      meta_cnt = 12'd0;
	logic [3:0]       match_pos = 4'd0;
	logic             in_title = 1'b0;
	logic             title_done = 1'b0;
	logic [11:0]      tcount = 12'd0;
	logic [11:0]      end_len = 12'd0;
	logic [11:0]      qpos = 12'd0;
	logic             saw_quote = 1'b0;
	logic             after_quote = 1'b0;

	beat_t       pending_beats [$];
	logic [7:0]  block_q [$];
	int          mismatches = 0;
	int          sent = 0;
	int          burst_left = 0;
	bit          hold_go = 1'b0;
	bit          hold_done = 1'b0;
	bit          big_done = 1'b0;
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_left = 0;

	icy_metadata_stream_splitter dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s_axis_tvalid       (s_axis_tvalid),
		.s_axis_tready       (s_axis_tready),
		.s_axis_tdata        (s_axis_tdata),
		.m_axis_tvalid       (m_axis_tvalid),
		.m_axis_tready       (m_axis_tready),
		.m_axis_tdata        (m_axis_tdata),
		.m_axis_tuser        (m_axis_tuser),
		.m_axis_tlast        (m_axis_tlast),
		.meta_interval_we    (meta_interval_we),
		.meta_interval_wdata (meta_interval_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] tag_char(input int pos);
		return TITLE_TAG[8*(12-pos) +: 8];
	endfunction

	function automatic logic [7:0] title_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return imss_pkg::CHAR_QUOTE;
		else if (r < 4)
			return imss_pkg::CHAR_SEMI;
		else if (r == 4)
			return imss_pkg::CHAR_S;
		else if (r == 5)
			return 8'($urandom);
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	function void clear_title();
		match_pos   = 4'd0;
		in_title    = 1'b0;
		title_done  = 1'b0;
		tcount      = 12'd0;
		end_len     = 12'd0;
		qpos        = 12'd0;
		saw_quote   = 1'b0;
		after_quote = 1'b0;
	endfunction

	function void want(input imss_pkg::kind_t k, input logic [7:0] d, input logic [11:0] i,
		input logic [11:0] l, input logic t);
		pending_beats.push_back('{k, d, i, l, t});
	endfunction

	// advances the deframer state by one byte and queues the beats it yields
	function void split_byte(input logic [7:0] b, input bit quiet);
		logic        closing;
		logic [11:0] i;
		logic [11:0] len;
		if (ph != imss_pkg::PH_META) begin
			if (audio_cnt != 0) begin
				audio_cnt = audio_cnt - 20'd1;
				if (!quiet)
					want(imss_pkg::KIND_AUDIO, b, 12'd0, 12'd0, 1'b1);
				return;
			end
			clear_title();
			if (b == 8'h00) begin
				audio_cnt = ivl;
			end else begin
				meta_cnt = {b, 4'h0};
				ph = imss_pkg::PH_META;
			end
			return;
		end
		closing = (meta_cnt <= 12'd1);
		meta_cnt = closing ? 12'd0 : meta_cnt - 12'd1;
		if (in_title) begin
			i = tcount;
			if (!title_done && after_quote && b == imss_pkg::CHAR_SEMI) begin
				end_len = i - 12'd1;
				title_done = 1'b1;
			end
			after_quote = (b == imss_pkg::CHAR_QUOTE);
			if (b == imss_pkg::CHAR_QUOTE) begin
				qpos = i;
				saw_quote = 1'b1;
			end
			if (!quiet)
				want(imss_pkg::KIND_CAND, b, i, 12'd0, !closing);
			tcount = i + 12'd1;
		end else begin
			if (match_pos < imss_pkg::PREFIX_LEN && b == tag_char(int'(match_pos)))
				match_pos = match_pos + 4'd1;
			else
				match_pos = (b == imss_pkg::CHAR_S) ? 4'd1 : 4'd0;
			if (match_pos >= imss_pkg::PREFIX_LEN) begin
				in_title = 1'b1;
				match_pos = 4'd0;
			end
		end
		if (closing) begin
			len = 12'd0;
			if (in_title)
				len = title_done ? end_len : (saw_quote ? qpos : 12'd0);
			if (!quiet)
				want(imss_pkg::KIND_FINISH, 8'h00, 12'd0, len, 1'b1);
			ph = imss_pkg::PH_AUDIO;
			audio_cnt = ivl;
			clear_title();
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		split_byte(b, typed);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		sent++;
		if (sent == 400)
			hold_go = 1'b1;
	endtask

	// waits for the splitter to drain, then writes the interval register
	task automatic set_interval(input logic [19:0] v);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		meta_interval_we    <= 1'b1;
		meta_interval_wdata <= v;
		@(negedge clk);
		meta_interval_we <= 1'b0;
		ivl = v;
		if (ph == imss_pkg::PH_AUDIO)
			audio_cnt = v;
		burst_left = 0;
	endtask

	task automatic build_block(input int size, input bit clean);
		int mode;
		int start;
		int cut;
		int k;
		block_q.delete();
		mode  = clean ? 0 : $urandom_range(0, 9);
		start = (mode == 1) ? size - 13 :
			(clean ? 0 : $urandom_range(0, (size - 13 < 6) ? size - 13 : 6));
		cut   = $urandom_range(1, 12);
		for (k = 0; k < size; k++) begin
			if (mode >= 8)
				block_q.push_back(title_char());
			else if (k < start)
				block_q.push_back(($urandom_range(0, 3) == 0) ?
					imss_pkg::CHAR_S : 8'($urandom));
			else if (k < start + 13)
				block_q.push_back((mode >= 6 && k == start + cut) ?
					8'($urandom) : tag_char(k - start));
			else
				block_q.push_back(title_char());
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_beats.size() == 0) begin
				$error("unexpected beat: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
				mismatches++;
			end else begin
				if (m_axis_tuser !== pending_beats[0].kind) begin
					$error("kind: expected %0d, got %0d", pending_beats[0].kind, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tdata[7:0] !== pending_beats[0].data) begin
					$error("data_byte: expected %h, got %h", pending_beats[0].data,
						m_axis_tdata[7:0]);
					mismatches++;
				end
				if (m_axis_tdata[19:8] !== pending_beats[0].idx) begin
					$error("title_index: expected %0d, got %0d", pending_beats[0].idx,
						m_axis_tdata[19:8]);
					mismatches++;
				end
				if (m_axis_tdata[31:20] !== pending_beats[0].len) begin
					$error("title_length: expected %0d, got %0d", pending_beats[0].len,
						m_axis_tdata[31:20]);
					mismatches++;
				end
				if (m_axis_tlast !== pending_beats[0].last) begin
					$error("last: expected %0d, got %0d", pending_beats[0].last, m_axis_tlast);
					mismatches++;
				end
				void'(pending_beats.pop_front());
			end
		end
	end

	// receiver: changing stall pattern, plus one long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (80) @(negedge clk);
			end
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 4) != 0);
				default:   m_axis_tready <= (rx_left % 3 == 0);
			endcase
		end
	end

	initial begin
		#1000000;
		$display("icy_metadata_stream_splitter_tb: done, errors");
		$finish;
	end

	initial begin
		int         r;
		int         len_b;
		int         half;
		logic [19:0] v;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (STEPS[k]) begin
			if (STEPS[k].cfg)
				set_interval(STEPS[k].cfg_val);
			if (STEPS[k].typed)
				want(imss_pkg::KIND_AUDIO, STEPS[k].b, 12'd0, 12'd0, 1'b1);
			send_byte(STEPS[k].b, STEPS[k].typed);
		end

		while (sent < 1850 || !big_done) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				v = 20'd0;
			else if (r == 3)
				v = 20'd1;
			else if (r == 4)
				v = INTERVAL_MAX;
			else
				v = 20'($urandom_range(2, 24));
			set_interval(v);
			if (v == INTERVAL_MAX) begin
				repeat ($urandom_range(3, 12)) send_byte(8'($urandom), 1'b0);
				continue;
			end
			repeat ($urandom_range(1, 4)) begin
				while (ph == imss_pkg::PH_AUDIO && audio_cnt != 0)
					send_byte(8'($urandom), 1'b0);
				r = $urandom_range(0, 19);
				if (!big_done && sent > 900) begin
					len_b = BIG_LEN;
					big_done = 1'b1;
				end else if (r < 3)
					len_b = 0;
				else if (r < 15)
					len_b = 1;
				else if (r < 18)
					len_b = 2;
				else
					len_b = $urandom_range(3, 5);
				send_byte(len_b[7:0], 1'b0);
				if (len_b != 0) begin
					build_block(len_b * 16, len_b == BIG_LEN);
					half = ($urandom_range(0, 7) == 0) ? block_q.size() / 2 : -1;
					while (block_q.size() != 0) begin
						if (block_q.size() == half)
							set_interval(20'($urandom_range(0, 24)));
						send_byte(block_q.pop_front(), 1'b0);
					end
				end
			end
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("icy_metadata_stream_splitter_tb: done, clean");
		else
			$display("icy_metadata_stream_splitter_tb: done, errors");
		$finish;
	end

endmodule
